@@ hdl/rmh_pkg.sv @@
// shared types and constants for the running median block
// no dependencies
`default_nettype none
package rmh_pkg;

  localparam int HEAP_DEPTH = 512;
  localparam int VALUE_W = 32;
  localparam int MED_W = 33;
  localparam int CNT_OUT_W = 11;
  localparam int OUT_DATA_W = 48;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // input kinds
  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // heap engine operations
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } heap_op_t;

  typedef struct packed {
    logic     start;
    heap_op_t op;
  } heap_cmd_t;

endpackage
`default_nettype wire

@@ hdl/rmh_heap.sv @@
// one binary heap: synchronous memory plus a sift-up / sift-down sequencer
// depends on rmh_pkg
`default_nettype none
module rmh_heap #(
  parameter int   DEPTH  = rmh_pkg::HEAP_DEPTH,
  parameter logic IS_MAX = 1'b1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rmh_pkg::heap_cmd_t                  cmd,
  input  wire logic signed [rmh_pkg::VALUE_W-1:0]  din,
  output logic                                     busy,
  output logic [$clog2(DEPTH+1)-1:0]               count,
  output logic signed [rmh_pkg::VALUE_W-1:0]       top
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);
  localparam int CW = AW + 2;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_UP_RD  = 8'b00000010,
    S_UP_CMP = 8'b00000100,
    S_DN_LRD = 8'b00001000,
    S_DN_LCP = 8'b00010000,
    S_DN_RL  = 8'b00100000,
    S_DN_RR  = 8'b01000000,
    S_DN_CMP = 8'b10000000
  } hstate_t;

  hstate_t state, state_next;

  logic signed [rmh_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [rmh_pkg::VALUE_W-1:0] rd_q;
  logic signed [rmh_pkg::VALUE_W-1:0] val, val_next;
  logic signed [rmh_pkg::VALUE_W-1:0] lv, lv_next;
  logic [AW-1:0] hole, hole_next;
  logic [NW-1:0] count_next;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic signed [rmh_pkg::VALUE_W-1:0] wd;

  logic [CW-1:0] lidx, ridx, cnt_ext;
  logic [AW-1:0] parent;
  logic          l_ok, r_ok;
  logic          l_wins, r_wins;
  logic signed [rmh_pkg::VALUE_W-1:0] bestv;

  function automatic logic above(input logic signed [rmh_pkg::VALUE_W-1:0] a,
                                 input logic signed [rmh_pkg::VALUE_W-1:0] b);
    return IS_MAX ? (a > b) : (a < b);
  endfunction

  // heap storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // child and parent indexes of the hole
  assign lidx    = {1'b0, hole, 1'b1};
  assign ridx    = lidx + CW'(1);
  assign cnt_ext = CW'(count);
  assign l_ok    = lidx < cnt_ext;
  assign r_ok    = ridx < cnt_ext;
  assign parent  = AW'((hole - AW'(1)) >> 1);
  assign l_wins  = above(lv, val);
  assign bestv   = l_wins ? lv : val;
  assign r_wins  = r_ok && above(rd_q, bestv);

  // sequencer
  always_comb begin
    state_next = state;
    val_next   = val;
    lv_next    = lv;
    hole_next  = hole;
    count_next = count;
    we = 1'b0;
    wa = hole;
    wd = val;
    ra = hole;
    unique case (state)
      S_IDLE: begin
        if (cmd.start) begin
          if (cmd.op == rmh_pkg::OP_PUSH) begin
            val_next   = din;
            hole_next  = AW'(count);
            count_next = count + NW'(1);
            state_next = S_UP_RD;
          end else begin
            count_next = count - NW'(1);
            hole_next  = AW'(count - NW'(1));
            state_next = (count == NW'(1)) ? S_IDLE : S_DN_LRD;
          end
        end
      end
      S_UP_RD: begin
        ra = parent;
        if (hole == '0) begin
          we = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (above(val, rd_q)) begin
          wd = rd_q;
          hole_next  = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DN_LRD: begin
        // read the last entry, which refills the root
        ra = hole;
        state_next = S_DN_LCP;
      end
      S_DN_LCP: begin
        val_next   = rd_q;
        hole_next  = '0;
        state_next = S_DN_RL;
      end
      S_DN_RL: begin
        ra = lidx[AW-1:0];
        if (!l_ok) begin
          we = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DN_RR;
        end
      end
      S_DN_RR: begin
        lv_next = rd_q;
        ra = ridx[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (r_wins) begin
          wd = rd_q;
          hole_next  = ridx[AW-1:0];
          state_next = S_DN_RL;
        end else if (l_wins) begin
          wd = lv;
          hole_next  = lidx[AW-1:0];
          state_next = S_DN_RL;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    val  <= val_next;
    lv   <= lv_next;
    hole <= hole_next;
    // shadow of the root entry
    if (we && wa == '0) top <= wd;
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

@@ hdl/running_median_two_heaps.sv @@
// running median top level: item sequencer, two heap engines, output register
// depends on rmh_pkg and rmh_heap
//
//   channel | signals                         | word
//   in      | s_tvalid s_tready s_tdata s_tuser | value, action
//   out     | m_tvalid m_tready m_tdata m_tuser | median_doubled+item_count, status
//
// a query goes via C_FIN to the output; an add first waits in C_ADD for its push sift
// a push sifts up from the new leaf, a pop refills the root from the last entry and sifts down
// a rebalance adds a pop and a second push, in C_RPOP and then C_RPUSH
// one item at a time; a new word is taken while the last result waits
// rst is synchronous; it empties both heaps and drops any pending result
`default_nettype none
module running_median_two_heaps #(
  parameter int HEAP_DEPTH = rmh_pkg::HEAP_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [31:0] value
  input  wire logic        s_tuser,  // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // [32:0] median_doubled, [43:33] item_count
  output logic [1:0]       m_tuser   // [1:0] status
);

  localparam int NW = $clog2(HEAP_DEPTH+1);

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_ADD   = 5'b00010,
    C_RPOP  = 5'b00100,
    C_RPUSH = 5'b01000,
    C_FIN   = 5'b10000
  } cstate_t;

  cstate_t state;
  rmh_pkg::heap_cmd_t lo_cmd, up_cmd;
  logic lo_busy, up_busy;
  logic [NW-1:0] lo_cnt, up_cnt;
  logic signed [31:0] lo_top, up_top, hdin, moved;
  logic is_query;
  rmh_pkg::status_t add_st;
  logic rebal_to_lower;

  logic signed [31:0] v;
  logic to_lower, full;
  logic [NW:0] lo_w, up_w, total;
  logic signed [32:0] med;
  logic accept, out_free;

  rmh_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b1)) u_lower (
    .clk(clk), .rst(rst), .cmd(lo_cmd), .din(hdin),
    .busy(lo_busy), .count(lo_cnt), .top(lo_top)
  );

  rmh_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b0)) u_upper (
    .clk(clk), .rst(rst), .cmd(up_cmd), .din(hdin),
    .busy(up_busy), .count(up_cnt), .top(up_top)
  );

  assign v        = s_tdata;
  assign s_tready = (state == C_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign lo_w     = (NW+1)'(lo_cnt);
  assign up_w     = (NW+1)'(up_cnt);
  assign total    = lo_w + up_w;

  // placement of a new sample
  assign to_lower = (lo_cnt == '0) || (up_cnt == '0) || (v <= lo_top);
  assign full = to_lower ? (lo_w == (NW+1)'(HEAP_DEPTH))
                         : (up_w == (NW+1)'(HEAP_DEPTH));

  // twice the median from the two roots
  always_comb begin
    if (total[0]) begin
      med = (up_cnt > lo_cnt) ? {up_top, 1'b0} : {lo_top, 1'b0};
    end else begin
      med = {up_top[31], up_top} + {lo_top[31], lo_top};
    end
  end

  // heap commands
  always_comb begin
    lo_cmd = '{start: 1'b0, op: rmh_pkg::OP_PUSH};
    up_cmd = '{start: 1'b0, op: rmh_pkg::OP_PUSH};
    hdin   = v;
    unique case (state)
      C_IDLE: begin
        if (accept && s_tuser == rmh_pkg::ACT_ADD && !full) begin
          lo_cmd.start = to_lower;
          up_cmd.start = !to_lower;
        end
      end
      C_ADD: begin
        if (!lo_busy && !up_busy) begin
          if (up_w > lo_w + (NW+1)'(1)) begin
            up_cmd = '{start: 1'b1, op: rmh_pkg::OP_POP};
          end else if (lo_w > up_w + (NW+1)'(1)) begin
            lo_cmd = '{start: 1'b1, op: rmh_pkg::OP_POP};
          end
        end
      end
      C_RPOP: begin
        hdin = moved;
        if (!lo_busy && !up_busy) begin
          lo_cmd.start = rebal_to_lower;
          up_cmd.start = !rebal_to_lower;
        end
      end
      default: ;
    endcase
  end

  // item sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == C_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (accept) begin
            is_query <= (s_tuser == rmh_pkg::ACT_QUERY);
            add_st   <= full ? rmh_pkg::ST_FULL : rmh_pkg::ST_OK;
            state    <= (s_tuser == rmh_pkg::ACT_ADD && !full) ? C_ADD : C_FIN;
          end
        end
        C_ADD: begin
          if (!lo_busy && !up_busy) begin
            if (up_w > lo_w + (NW+1)'(1)) begin
              moved <= up_top;
              rebal_to_lower <= 1'b1;
              state <= C_RPOP;
            end else if (lo_w > up_w + (NW+1)'(1)) begin
              moved <= lo_top;
              rebal_to_lower <= 1'b0;
              state <= C_RPOP;
            end else begin
              state <= C_FIN;
            end
          end
        end
        C_RPOP: begin
          if (!lo_busy && !up_busy) state <= C_RPUSH;
        end
        C_RPUSH: begin
          if (!lo_busy && !up_busy) state <= C_FIN;
        end
        C_FIN: begin
          if (out_free) begin
            m_tdata[47:44] <= '0;
            m_tdata[43:33] <= rmh_pkg::CNT_OUT_W'(total);
            if (is_query) begin
              if (total == '0) begin
                m_tuser <= rmh_pkg::ST_EMPTY;
                m_tdata[32:0] <= '0;
              end else begin
                m_tuser <= rmh_pkg::ST_OK;
                m_tdata[32:0] <= med;
              end
            end else begin
              m_tuser <= add_st;
              m_tdata[32:0] <= '0;
            end
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/rmh_checker.sv @@
// port-level checks for the running median block, bound to the top level
// depends on rmh_pkg and running_median_two_heaps ports only
`default_nettype none
module rmh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a word that is not ok carries no median
  a_zero_med: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != rmh_pkg::ST_OK |-> m_tdata[32:0] == 33'd0)
    else $error("median set on a non-ok word");

  // empty query reports zero held
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rmh_pkg::ST_EMPTY |-> m_tdata[43:33] == 11'd0)
    else $error("empty status with nonzero count");

  // an accepted word is never followed by another at the next edge
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

endmodule

bind running_median_two_heaps rmh_checker u_rmh_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
